@@ hdl/bounded_deque_push_pop_list_unit_defines.svh @@
// Assertion macros for the deque unit checker.
`ifndef BOUNDED_DEQUE_PUSH_POP_LIST_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_PUSH_POP_LIST_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bdq_pkg.sv @@
// Shared types, constants and index helpers for the deque unit.
package bdq_pkg;

	localparam int DEPTH   = 32;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int WIDTH   = 32;
	// command queue between front and back; power of two
	localparam int Q_DEPTH = 2;
	localparam int QW      = $clog2(Q_DEPTH);
	localparam int QCW     = $clog2(Q_DEPTH + 1);

	typedef logic [AW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;

	localparam idx_t IDX_LAST = AW'(DEPTH - 1);
	localparam cnt_t CNT_FULL = CW'(DEPTH);
	localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

	// action codes on the input port
	localparam logic [1:0] ACT_INS_FRONT = 2'd0;
	localparam logic [1:0] ACT_INS_BACK  = 2'd1;
	localparam logic [1:0] ACT_REMOVE    = 2'd2;
	localparam logic [1:0] ACT_LIST      = 2'd3;

	// status codes on the result port
	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_REMOVED = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_LISTED  = 3'd4;

	typedef enum logic [1:0] {
		OP_INS_FRONT,
		OP_INS_BACK,
		OP_REMOVE,
		OP_LIST
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [WIDTH-1:0] value;
	} cmd_t;

	function automatic idx_t idx_inc(input idx_t a);
		return (a == IDX_LAST) ? '0 : idx_t'(a + idx_t'(1));
	endfunction

	function automatic idx_t idx_dec(input idx_t a);
		return (a == '0) ? IDX_LAST : idx_t'(a - idx_t'(1));
	endfunction

	// ring position a + n, with a < DEPTH and n <= DEPTH
	function automatic idx_t idx_add(input idx_t a, input cnt_t n);
		logic [CW:0] s;
		s = (CW + 1)'(a) + (CW + 1)'(n);
		if (s >= DEPTH_W)
			s = s - DEPTH_W;
		return s[AW-1:0];
	endfunction

endpackage

@@ hdl/bdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/bdq_front.sv @@
// Front end: accepts words, decodes the action and queues commands.
module bdq_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             action,
	input  logic signed [31:0]     value,
	output logic                   cmd_valid,
	output bdq_pkg::cmd_t          cmd,
	input  logic                   cmd_pop
);

	bdq_pkg::cmd_t                 slot_q [bdq_pkg::Q_DEPTH];
	logic [bdq_pkg::QW-1:0]        wr_ptr_q;
	logic [bdq_pkg::QW-1:0]        rd_ptr_q;
	logic [bdq_pkg::QCW-1:0]       fill_q;
	bdq_pkg::cmd_t                 in_cmd;
	logic                          push;

	always_comb begin
		in_cmd.value = value;
		unique case (action)
			bdq_pkg::ACT_INS_FRONT: in_cmd.op = bdq_pkg::OP_INS_FRONT;
			bdq_pkg::ACT_INS_BACK:  in_cmd.op = bdq_pkg::OP_INS_BACK;
			bdq_pkg::ACT_REMOVE:    in_cmd.op = bdq_pkg::OP_REMOVE;
			bdq_pkg::ACT_LIST:      in_cmd.op = bdq_pkg::OP_LIST;
			default:                in_cmd.op = bdq_pkg::OP_LIST;
		endcase
	end

	assign busy      = (fill_q == bdq_pkg::QCW'(bdq_pkg::Q_DEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (fill_q != '0);
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bdq_pkg::QW'(wr_ptr_q + 1'b1);
			if (cmd_pop)
				rd_ptr_q <= bdq_pkg::QW'(rd_ptr_q + 1'b1);
			if (push && !cmd_pop)
				fill_q <= bdq_pkg::QCW'(fill_q + 1'b1);
			else if (cmd_pop && !push)
				fill_q <= bdq_pkg::QCW'(fill_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= in_cmd;
	end

endmodule

@@ hdl/bdq_back.sv @@
// Back end: owns the ring pointers, runs inserts, removes and list walks.
module bdq_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  bdq_pkg::cmd_t              cmd,
	output logic                       cmd_pop,
	output logic                       ram_we,
	output bdq_pkg::idx_t              ram_waddr,
	output logic [bdq_pkg::WIDTH-1:0]  ram_wdata,
	output logic                       ram_re,
	output bdq_pkg::idx_t              ram_raddr,
	input  logic [bdq_pkg::WIDTH-1:0]  ram_rdata,
	output logic                       strobe,
	output logic [2:0]                 status,
	output logic signed [31:0]         result_value,
	output logic                       last
);

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] status;
		logic       last;
		logic       from_ram;
	} res_t;

	state_t         state_q, state_d;
	bdq_pkg::idx_t  front_q, front_d;
	bdq_pkg::cnt_t  count_q, count_d;
	bdq_pkg::cnt_t  idx_q, idx_d;
	res_t           res_q, res_d;
	logic           full, empty;

	assign full  = (count_q == bdq_pkg::CNT_FULL);
	assign empty = (count_q == '0);

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		count_d   = count_q;
		idx_d     = idx_q;
		res_d     = '0;
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = front_q;
		ram_wdata = cmd.value;
		ram_re    = 1'b0;
		ram_raddr = front_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_pop     = 1'b1;
					res_d.valid = 1'b1;
					res_d.last  = 1'b1;
					unique case (cmd.op)
						bdq_pkg::OP_INS_FRONT: begin
							if (full) begin
								res_d.status = bdq_pkg::ST_FULL;
							end else begin
								front_d      = bdq_pkg::idx_dec(front_q);
								ram_we       = 1'b1;
								ram_waddr    = bdq_pkg::idx_dec(front_q);
								count_d      = bdq_pkg::cnt_t'(count_q + 1'b1);
								res_d.status = bdq_pkg::ST_STORED;
							end
						end
						bdq_pkg::OP_INS_BACK: begin
							if (full) begin
								res_d.status = bdq_pkg::ST_FULL;
							end else begin
								ram_we       = 1'b1;
								ram_waddr    = bdq_pkg::idx_add(front_q, count_q);
								count_d      = bdq_pkg::cnt_t'(count_q + 1'b1);
								res_d.status = bdq_pkg::ST_STORED;
							end
						end
						bdq_pkg::OP_REMOVE: begin
							if (empty) begin
								res_d.status = bdq_pkg::ST_EMPTY;
							end else begin
								ram_re         = 1'b1;
								front_d        = bdq_pkg::idx_inc(front_q);
								count_d        = bdq_pkg::cnt_t'(count_q - 1'b1);
								res_d.status   = bdq_pkg::ST_REMOVED;
								res_d.from_ram = 1'b1;
							end
						end
						bdq_pkg::OP_LIST: begin
							if (empty) begin
								res_d.status = bdq_pkg::ST_EMPTY;
							end else begin
								// first entry read here, the rest in S_LIST
								ram_re         = 1'b1;
								res_d.status   = bdq_pkg::ST_LISTED;
								res_d.from_ram = 1'b1;
								res_d.last     = (count_q == bdq_pkg::cnt_t'(1));
								if (count_q != bdq_pkg::cnt_t'(1)) begin
									state_d = S_LIST;
									idx_d   = bdq_pkg::cnt_t'(1);
								end
							end
						end
					endcase
				end
			end
			S_LIST: begin
				ram_re         = 1'b1;
				ram_raddr      = bdq_pkg::idx_add(front_q, idx_q);
				res_d.valid    = 1'b1;
				res_d.status   = bdq_pkg::ST_LISTED;
				res_d.from_ram = 1'b1;
				res_d.last     = (bdq_pkg::cnt_t'(idx_q + 1'b1) == count_q);
				idx_d          = bdq_pkg::cnt_t'(idx_q + 1'b1);
				if (res_d.last)
					state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			res_q   <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			res_q   <= res_d;
		end
	end

	// read data lands in the same cycle as the registered result tag
	assign strobe       = res_q.valid;
	assign status       = res_q.status;
	assign last         = res_q.last;
	assign result_value = res_q.from_ram ? signed'(ram_rdata) : '0;

endmodule

@@ hdl/bounded_deque_push_pop_list_unit.sv @@
// Bounded double-ended queue of signed 32-bit words, ring buffer based.
//
// Input: pulse start with action and value; the word is taken on a clock
// edge where start is high and busy is low. Actions: insert front, insert
// back, remove front, list all entries.
// Output: each result word shows on status, result_value and last for one
// cycle with strobe high. There is no backpressure on the result side.
// A two-entry command queue sits between the decode front end and the
// execution back end, so start can be pulsed while the back end works.
// The back end pops each command from the command queue and registers its
// result together with the RAM read data. Inserts and removes run at one
// word per cycle unless a list walk holds the back end. A list reads each
// entry, one RAM read per cycle; busy rises when the command queue fills.
// Insert into a full store gives status full; remove or list on an empty
// store gives one empty result. Reset clears the pointers, the count and
// the command queue; the entry RAM is not cleared and is read only where
// written.
module bounded_deque_push_pop_list_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	output logic               strobe,
	output logic [2:0]         status,
	output logic signed [31:0] result_value,
	output logic               last
);

	logic                        cmd_valid;
	logic                        cmd_pop;
	bdq_pkg::cmd_t               cmd;
	logic                        ram_we;
	bdq_pkg::idx_t               ram_waddr;
	logic [bdq_pkg::WIDTH-1:0]   ram_wdata;
	logic                        ram_re;
	bdq_pkg::idx_t               ram_raddr;
	logic [bdq_pkg::WIDTH-1:0]   ram_rdata;

	bdq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	bdq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.strobe       (strobe),
		.status       (status),
		.result_value (result_value),
		.last         (last)
	);

	bdq_ram #(
		.WIDTH (bdq_pkg::WIDTH),
		.DEPTH (bdq_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ hdl/bdq_checker.sv @@
// Port-level checker for the deque unit, bound to the top level.
`include "bounded_deque_push_pop_list_unit_defines.svh"

module bdq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               strobe,
	input logic [2:0]         status,
	input logic signed [31:0] result_value,
	input logic               last
);

	`BDQ_ASSERT_NOW(a_status_code, strobe, status == bdq_pkg::ST_STORED || status == bdq_pkg::ST_FULL || status == bdq_pkg::ST_REMOVED || status == bdq_pkg::ST_EMPTY || status == bdq_pkg::ST_LISTED, "status code out of range")
	`BDQ_ASSERT_NOW(a_zero_value, strobe && (status == bdq_pkg::ST_STORED || status == bdq_pkg::ST_FULL || status == bdq_pkg::ST_EMPTY), result_value == '0, "nonzero value on status word")
	`BDQ_ASSERT_NOW(a_single_last, strobe && status != bdq_pkg::ST_LISTED, last, "single result word without last")
	`BDQ_ASSERT_NEXT(a_list_burst, strobe && !last, strobe && status == bdq_pkg::ST_LISTED, "list burst broken")

endmodule

bind bounded_deque_push_pop_list_unit bdq_checker u_bdq_checker (.*);
